FILE: src/msw_pkg.sv
// Shared types and constants for the mode switch supervisor.
package msw_pkg;

    localparam int unsigned MODE_W    = 2;
    localparam int unsigned TARGET_W  = 3;
    localparam int unsigned STEP_W    = 8;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;

    // Input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'b1;

    localparam logic [STEP_W-1:0]    TICK_STEP_RST = 8'd25;
    localparam logic [ELAPSED_W-1:0] TIMEOUT_RST   = 16'd2000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 16'hFFFF;

    // Mode codes
    localparam logic [TARGET_W-1:0] MODE_0 = 3'd0;
    localparam logic [TARGET_W-1:0] MODE_1 = 3'd1;
    localparam logic [TARGET_W-1:0] MODE_2 = 3'd2;
    localparam logic [TARGET_W-1:0] MODE_3 = 3'd3;

    typedef struct packed {
        logic                opcode;
        logic [TARGET_W-1:0] requested_mode;
        logic                sense_bz;
        logic                sense_gvi;
        logic                sense_btr;
    } t_item;

    typedef struct packed {
        logic              armed;
        logic [MODE_W-1:0] current_mode;
        logic              error_flag;
        logic              bz_power_clear;
        logic              aux_power_clear;
        logic              gvi_power_write;
        logic              gvi_power_level;
        logic              btr_power_write;
        logic              btr_power_level;
    } t_result;

    typedef struct packed {
        logic                 armed;
        logic [MODE_W-1:0]    mode_now;
        logic [TARGET_W-1:0]  mode_target;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 error_sticky;
    } t_state;

endpackage

FILE: src/msw_ifs.sv
// Handshake channel interfaces: input items, results, configuration writes.
interface msw_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [msw_pkg::TARGET_W-1:0]  requested_mode;
    logic                          sense_bz;
    logic                          sense_gvi;
    logic                          sense_btr;

    modport source (output valid, opcode, requested_mode, sense_bz, sense_gvi, sense_btr,
                     input ready);
    modport sink   (input valid, opcode, requested_mode, sense_bz, sense_gvi, sense_btr,
                     output ready);
endinterface

interface msw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        armed;
    logic [msw_pkg::MODE_W-1:0]  current_mode;
    logic                        error_flag;
    logic                        bz_power_clear;
    logic                        aux_power_clear;
    logic                        gvi_power_write;
    logic                        gvi_power_level;
    logic                        btr_power_write;
    logic                        btr_power_level;

    modport source (output valid, armed, current_mode, error_flag, bz_power_clear,
                     aux_power_clear, gvi_power_write, gvi_power_level, btr_power_write,
                     btr_power_level, input ready);
    modport sink   (input valid, armed, current_mode, error_flag, bz_power_clear,
                     aux_power_clear, gvi_power_write, gvi_power_level, btr_power_write,
                     btr_power_level, output ready);
endinterface

interface msw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [msw_pkg::CFG_IDX_W-1:0]  index;
    logic [msw_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/mode_switch_supervisor.sv
// Mode switch supervisor top level: input register, decision logic, result register.
// Result path: an input transfer fills the input reg; the result reg loads when free.
// Throughput: one item per cycle unless the sink stalls; one eval stage updates state.
// Reset: synchronous active-low; clears valids, supervisor state, error flag,
//        and loads default step (25 ms) and timeout (2000 ms).
module mode_switch_supervisor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msw_in_if.sink     i_in,
    msw_out_if.source  o_res,
    msw_cfg_if.sink    i_cfg
);
    // config registers
    logic [msw_pkg::STEP_W-1:0]    r_tick_step;
    logic [msw_pkg::ELAPSED_W-1:0] r_timeout;

    // supervisor state and its next value from the eval stage
    msw_pkg::t_state  r_state;
    msw_pkg::t_state  n_state;

    logic             stage_valid;
    msw_pkg::t_item   stage_item;
    msw_pkg::t_result eval_result;
    logic             out_free;
    logic             adv;

    // An item leaves the input register when the result register can take it.
    // State commits on the same edge, so the next item sees the updated state.
    assign adv = stage_valid && out_free;

    // Config writes land any time; the user only writes while idle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= msw_pkg::TICK_STEP_RST;
            r_timeout   <= msw_pkg::TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == msw_pkg::REG_TICK_STEP) begin
                r_tick_step <= i_cfg.data[msw_pkg::STEP_W-1:0];
            end else begin
                r_timeout <= i_cfg.data[msw_pkg::ELAPSED_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    msw_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    msw_eval u_eval (
        .i_state   (r_state),
        .i_item    (stage_item),
        .i_step    (r_tick_step),
        .i_timeout (r_timeout),
        .o_state   (n_state),
        .o_result  (eval_result)
    );

    msw_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_result (eval_result),
        .o_free   (out_free),
        .o_res    (o_res)
    );
endmodule

FILE: src/msw_in_reg.sv
// Input register stage: captures one item per transfer.
module msw_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    msw_in_if.sink           i_in,
    input  logic             i_adv,
    output logic             o_valid,
    output msw_pkg::t_item   o_item
);
    logic           r_valid;
    msw_pkg::t_item r_item;

    assign i_in.ready = !r_valid || i_adv;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.opcode         <= i_in.opcode;
            r_item.requested_mode <= i_in.requested_mode;
            r_item.sense_bz       <= i_in.sense_bz;
            r_item.sense_gvi      <= i_in.sense_gvi;
            r_item.sense_btr      <= i_in.sense_btr;
        end
    end
endmodule

FILE: src/msw_eval.sv
// Per-item decision logic: elapsed update, feedback rules, power-line strobes.
module msw_eval (
    input  msw_pkg::t_state                     i_state,
    input  msw_pkg::t_item                      i_item,
    input  logic [msw_pkg::STEP_W-1:0]          i_step,
    input  logic [msw_pkg::ELAPSED_W-1:0]       i_timeout,
    output msw_pkg::t_state                     o_state,
    output msw_pkg::t_result                    o_result
);
    logic [msw_pkg::ELAPSED_W:0]   sum;
    logic [msw_pkg::ELAPSED_W-1:0] elapsed_sat;
    logic                          tout;
    logic                          ok;
    logic                          bzc, auxc, gw, gl, bw, bl;
    logic                          from2, from3;
    msw_pkg::t_state               ns;

    assign sum         = {1'b0, i_state.elapsed_ms} + {{(msw_pkg::ELAPSED_W+1-msw_pkg::STEP_W){1'b0}},
                                                       i_step};
    assign elapsed_sat = sum[msw_pkg::ELAPSED_W] ? msw_pkg::ELAPSED_MAX
                                                 : sum[msw_pkg::ELAPSED_W-1:0];
    assign tout        = elapsed_sat >= i_timeout;
    assign from2       = i_state.mode_now == msw_pkg::MODE_2[msw_pkg::MODE_W-1:0];
    assign from3       = i_state.mode_now == msw_pkg::MODE_3[msw_pkg::MODE_W-1:0];

    always_comb begin
        ns   = i_state;
        ok   = 1'b0;
        bzc  = 1'b0;
        auxc = 1'b0;
        gw   = 1'b0;
        gl   = 1'b0;
        bw   = 1'b0;
        bl   = 1'b0;
        if (i_item.opcode == msw_pkg::OP_START) begin
            ns.mode_target = i_item.requested_mode;
            ns.elapsed_ms  = '0;
            ns.armed       = 1'b1;
        end else if (i_state.armed) begin
            ns.elapsed_ms = elapsed_sat;
            case (i_state.mode_target)
                msw_pkg::MODE_0: begin
                    case ({1'b0, i_state.mode_now})
                        msw_pkg::MODE_0: ok = i_item.sense_bz && i_item.sense_gvi
                                              && !i_item.sense_btr;
                        msw_pkg::MODE_1: ok = i_item.sense_bz;
                        msw_pkg::MODE_2: ok = i_item.sense_gvi;
                        default:         ok = !i_item.sense_btr;
                    endcase
                    bzc = ok || tout;
                    if (!ok && tout) begin
                        if (from2 && i_item.sense_bz) begin
                            gw = 1'b1;
                            gl = 1'b1;
                        end
                        if (from3) begin
                            bw = 1'b1;
                        end
                    end
                end
                msw_pkg::MODE_1: begin
                    ok   = !i_item.sense_bz;
                    auxc = ok || tout;
                end
                msw_pkg::MODE_2: begin
                    ok = !i_item.sense_gvi;
                    if (!ok && tout) begin
                        if (from2) begin
                            gw = i_item.sense_bz;
                            gl = i_item.sense_bz;
                        end else begin
                            gw = 1'b1;
                        end
                    end
                end
                msw_pkg::MODE_3: begin
                    ok = i_item.sense_btr;
                    if (!ok && tout) begin
                        bw = 1'b1;
                        bl = !from3;
                    end
                end
                default: begin
                    // target out of range: drop out on this tick
                    ns.armed      = 1'b0;
                    ns.elapsed_ms = '0;
                end
            endcase
            if (!i_state.mode_target[msw_pkg::TARGET_W-1]) begin
                if (ok) begin
                    ns.mode_now   = i_state.mode_target[msw_pkg::MODE_W-1:0];
                    ns.armed      = 1'b0;
                    ns.elapsed_ms = '0;
                end else if (tout) begin
                    ns.error_sticky = 1'b1;
                    ns.armed        = 1'b0;
                    ns.elapsed_ms   = '0;
                end
            end
        end
    end

    assign o_state                  = ns;
    assign o_result.armed           = ns.armed;
    assign o_result.current_mode    = ns.mode_now;
    assign o_result.error_flag      = ns.error_sticky;
    assign o_result.bz_power_clear  = bzc;
    assign o_result.aux_power_clear = auxc;
    assign o_result.gvi_power_write = gw;
    assign o_result.gvi_power_level = gl;
    assign o_result.btr_power_write = bw;
    assign o_result.btr_power_level = bl;
endmodule

FILE: src/msw_out_reg.sv
// Result register: holds a result until the sink takes it.
module msw_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  msw_pkg::t_result  i_result,
    output logic              o_free,
    msw_out_if.source         o_res
);
    logic             r_valid;
    msw_pkg::t_result r_result;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.armed           = r_result.armed;
    assign o_res.current_mode    = r_result.current_mode;
    assign o_res.error_flag      = r_result.error_flag;
    assign o_res.bz_power_clear  = r_result.bz_power_clear;
    assign o_res.aux_power_clear = r_result.aux_power_clear;
    assign o_res.gvi_power_write = r_result.gvi_power_write;
    assign o_res.gvi_power_level = r_result.gvi_power_level;
    assign o_res.btr_power_write = r_result.btr_power_write;
    assign o_res.btr_power_level = r_result.btr_power_level;
endmodule

FILE: src/msw_chk.sv
// Port-level assertion checker for the mode switch supervisor, with its bind.
module msw_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_armed,
    input logic [msw_pkg::MODE_W-1:0]  i_current_mode,
    input logic                        i_error_flag,
    input logic                        i_bz_power_clear,
    input logic                        i_aux_power_clear,
    input logic                        i_gvi_power_write,
    input logic                        i_gvi_power_level,
    input logic                        i_btr_power_write,
    input logic                        i_btr_power_level
);
    logic r_err_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_error_flag) begin
            r_err_seen <= 1'b1;
        end
    end

    // stalled result holds valid, mode, error flag and armed
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_current_mode)
            && $stable(i_error_flag) && $stable(i_armed))
        else $error("result changed while stalled");

    // error is sticky across transfers
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_err_seen |-> i_error_flag)
        else $error("error flag dropped");

    // any power strobe ends supervision
    a_strobe_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_bz_power_clear || i_aux_power_clear || i_gvi_power_write
            || i_btr_power_write) |-> !i_armed)
        else $error("strobe while still armed");

    // levels only with their write strobe; two clears never together
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_gvi_power_level || i_gvi_power_write)
            && (!i_btr_power_level || i_btr_power_write)
            && !(i_bz_power_clear && i_aux_power_clear))
        else $error("inconsistent power strobes");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind mode_switch_supervisor msw_chk u_msw_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_armed           (o_res.armed),
    .i_current_mode    (o_res.current_mode),
    .i_error_flag      (o_res.error_flag),
    .i_bz_power_clear  (o_res.bz_power_clear),
    .i_aux_power_clear (o_res.aux_power_clear),
    .i_gvi_power_write (o_res.gvi_power_write),
    .i_gvi_power_level (o_res.gvi_power_level),
    .i_btr_power_write (o_res.btr_power_write),
    .i_btr_power_level (o_res.btr_power_level)
);
